// ===== rtl/rgb_to_hsv_converter_macros.svh =====
// Assertion helpers for the RGB to HSV converter.
// Both sample on the rising edge of i_clk and are off while reset is held.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBHSV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rgb_to_hsv_converter assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define RGBHSV_ASSERT_DLY(label, ante, dly, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##(dly) (cons)) else $error("rgb_to_hsv_converter assertion failed");

`endif

// ===== rtl/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

    localparam int CHANNEL_BITS = 16;
    localparam int HUE_BITS     = 15;

    // Both quotients are produced by the same number of restoring steps.
    localparam int DIV_STEPS = (CHANNEL_BITS > HUE_BITS) ? CHANNEL_BITS : HUE_BITS;
    localparam int NUM_BITS  = CHANNEL_BITS + DIV_STEPS;
    localparam int MAG_BITS  = CHANNEL_BITS + 3;

    // Sixty degrees in 1/64 degree units is 4096 - 256.
    localparam int HUE_SHIFT_HI = 12;
    localparam int HUE_SHIFT_LO = 8;
    localparam int HUE_SIXTY    = (1 << HUE_SHIFT_HI) - (1 << HUE_SHIFT_LO);
    localparam logic [HUE_BITS-1:0] HUE_FULL_TURN = HUE_BITS'(6 * HUE_SIXTY);

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_rgb_in;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } t_hsv_out;

    // One lane of the restoring divider. wq holds the dividend bits not yet
    // consumed in its upper part and the quotient bits found so far below them.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] rem;
        logic [DIV_STEPS-1:0]    wq;
        logic [CHANNEL_BITS-1:0] den;
    } t_div_lane;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] brightness;
        logic                    hue_neg;
        logic                    hue_zero;
        logic                    sat_zero;
    } t_side;

    typedef struct packed {
        t_div_lane sat;
        t_div_lane hue;
        t_side     side;
    } t_div_item;

endpackage

// ===== rtl/rgb_to_hsv_converter.sv =====
// RGB to HSV converter, fully pipelined: one item may start in every cycle.
// Items pass through the prep registers, the divider stages with one restoring
// divider step per stage, and the output register that drives o_strobe.
// busy is always low, so throughput is one item per cycle, and the receiver
// cannot stall. Synchronous active-low reset clears only the valid bits.
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rgbhsv_pkg::t_rgb_in  i_item,
    output logic                 o_strobe,
    output rgbhsv_pkg::t_hsv_out o_item
);
    import rgbhsv_pkg::*;

    localparam int PIPE_LATENCY = DIV_STEPS + 4;

    logic      prep_vld;
    t_div_item prep_item;
    logic      div_vld;
    t_div_item div_item;

    logic      r_out_vld;
    t_hsv_out  r_out;
    t_hsv_out  n_out;

    logic [HUE_BITS-1:0] quot_hue;

    assign busy = 1'b0;

    rgbhsv_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_item  (i_item),
        .o_vld   (prep_vld),
        .o_item  (prep_item)
    );

    rgbhsv_divpipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (prep_vld),
        .i_item  (prep_item),
        .o_vld   (div_vld),
        .o_item  (div_item)
    );

    // A negative hue wraps by a full turn unless it truncated to zero.
    always_comb begin
        quot_hue         = div_item.hue.wq[HUE_BITS-1:0];
        n_out.brightness = div_item.side.brightness;
        n_out.saturation = div_item.side.sat_zero ? '0
                                                  : div_item.sat.wq[CHANNEL_BITS-1:0];
        if (div_item.side.hue_zero) begin
            n_out.hue = '0;
        end else if (div_item.side.hue_neg && quot_hue != '0) begin
            n_out.hue = HUE_FULL_TURN - quot_hue;
        end else begin
            n_out.hue = quot_hue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_item   = r_out;

    `RGBHSV_ASSERT_DLY(a_latency, start, PIPE_LATENCY, o_strobe)
    `RGBHSV_ASSERT_IMP(a_no_spurious, o_strobe, $past(start, PIPE_LATENCY))
    `RGBHSV_ASSERT_IMP(a_hue_range, o_strobe, o_item.hue < HUE_FULL_TURN)
    `RGBHSV_ASSERT_IMP(a_black_sat, o_strobe && o_item.brightness == '0, o_item.saturation == '0)
    `RGBHSV_ASSERT_IMP(a_grey_hue, o_strobe && o_item.saturation == '0, o_item.hue == '0)

endmodule

// ===== rtl/rgbhsv_prep.sv =====
module rgbhsv_prep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  rgbhsv_pkg::t_rgb_in   i_item,
    output logic                  o_vld,
    output rgbhsv_pkg::t_div_item o_item
);
    import rgbhsv_pkg::*;

    // Input register.
    logic    r_a_vld;
    t_rgb_in r_a;

    // Max, delta (max minus min) and hue numerator magnitude.
    logic                    r_b_vld;
    logic [CHANNEL_BITS-1:0] r_b_hi;
    logic [CHANNEL_BITS-1:0] r_b_delta;
    logic [MAG_BITS-1:0]     r_b_mag;
    logic                    r_b_neg;

    logic                    r_c_vld;
    t_div_item               r_c;

    logic [CHANNEL_BITS-1:0] n_hi;
    logic [CHANNEL_BITS-1:0] n_lo;
    logic [CHANNEL_BITS-1:0] n_delta;
    logic [MAG_BITS-1:0]     n_mag;
    logic                    n_neg;
    logic [NUM_BITS-1:0]     sat_num;
    logic [NUM_BITS-1:0]     hue_num;
    t_div_item               n_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    // Red wins ties, then green.
    always_comb begin
        n_neg = 1'b0;
        if (r_a.red >= r_a.green && r_a.red >= r_a.blue) begin
            n_hi = r_a.red;
        end else if (r_a.green >= r_a.blue) begin
            n_hi = r_a.green;
        end else begin
            n_hi = r_a.blue;
        end
        if (r_a.red <= r_a.green && r_a.red <= r_a.blue) begin
            n_lo = r_a.red;
        end else if (r_a.green <= r_a.blue) begin
            n_lo = r_a.green;
        end else begin
            n_lo = r_a.blue;
        end
        n_delta = n_hi - n_lo;
        if (r_a.red >= r_a.green && r_a.red >= r_a.blue) begin
            n_neg = r_a.green < r_a.blue;
            n_mag = n_neg ? MAG_BITS'(r_a.blue - r_a.green)
                          : MAG_BITS'(r_a.green - r_a.blue);
        end else if (r_a.green >= r_a.blue) begin
            n_mag = (MAG_BITS'(n_delta) << 1) + MAG_BITS'(r_a.blue) - MAG_BITS'(r_a.red);
        end else begin
            n_mag = (MAG_BITS'(n_delta) << 2) + MAG_BITS'(r_a.red) - MAG_BITS'(r_a.green);
        end
    end

    // Both numerators are constant multiples, built from shifts.
    always_comb begin
        sat_num = (NUM_BITS'(r_b_delta) << CHANNEL_BITS) - NUM_BITS'(r_b_delta);
        hue_num = (NUM_BITS'(r_b_mag) << HUE_SHIFT_HI) - (NUM_BITS'(r_b_mag) << HUE_SHIFT_LO);
        n_c.sat.rem          = sat_num[NUM_BITS-1:DIV_STEPS];
        n_c.sat.wq           = sat_num[DIV_STEPS-1:0];
        n_c.sat.den          = r_b_hi;
        n_c.hue.rem          = hue_num[NUM_BITS-1:DIV_STEPS];
        n_c.hue.wq           = hue_num[DIV_STEPS-1:0];
        n_c.hue.den          = r_b_delta;
        n_c.side.brightness  = r_b_hi;
        n_c.side.hue_neg     = r_b_neg;
        n_c.side.hue_zero    = (r_b_delta == '0);
        n_c.side.sat_zero    = (r_b_hi == '0);
    end

    always_ff @(posedge i_clk) begin
        r_a       <= i_item;
        r_b_hi    <= n_hi;
        r_b_delta <= n_delta;
        r_b_mag   <= n_mag;
        r_b_neg   <= n_neg;
        r_c       <= n_c;
    end

    assign o_vld  = r_c_vld;
    assign o_item = r_c;

endmodule

// ===== rtl/rgbhsv_divpipe.sv =====
module rgbhsv_divpipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  rgbhsv_pkg::t_div_item i_item,
    output logic                  o_vld,
    output rgbhsv_pkg::t_div_item o_item
);
    import rgbhsv_pkg::*;

    // One restoring step: bring down the next dividend bit and subtract
    // the divisor where it fits.
    function automatic t_div_lane div_step(input t_div_lane x);
        logic [CHANNEL_BITS:0] trial;
        logic                  fits;
        t_div_lane             y;
        trial = {x.rem, x.wq[DIV_STEPS-1]};
        fits  = trial >= {1'b0, x.den};
        y.den = x.den;
        y.rem = fits ? CHANNEL_BITS'(trial - {1'b0, x.den}) : trial[CHANNEL_BITS-1:0];
        y.wq  = {x.wq[DIV_STEPS-2:0], fits};
        return y;
    endfunction

    logic      r_vld   [DIV_STEPS];
    t_div_item r_stage [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        t_div_item src;
        logic      src_vld;
        t_div_item n_stage;

        if (i == 0) begin : g_first
            assign src     = i_item;
            assign src_vld = i_vld;
        end else begin : g_next
            assign src     = r_stage[i-1];
            assign src_vld = r_vld[i-1];
        end

        always_comb begin
            n_stage.sat  = div_step(src.sat);
            n_stage.hue  = div_step(src.hue);
            n_stage.side = src.side;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_stage[i] <= n_stage;
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_item = r_stage[DIV_STEPS-1];

endmodule
